@@ rtl/core/rmfq_pkg.sv @@
// Shared widths, request codes and result type for the range mode frequency query block.
`timescale 1ns / 1ps
`default_nettype none
package rmfq_pkg;

    localparam int unsigned POS_W = 12;
    localparam int unsigned VAL_W = 12;
    localparam int unsigned CNT_W = 13;
    localparam int unsigned VAL_DEPTH = 1 << VAL_W;

    localparam int unsigned S_TDATA_W = 4 * POS_W;
    localparam int unsigned M_TDATA_W = 32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic             bad_range;
        logic [CNT_W-1:0] answer;
        logic [CNT_W-1:0] mode_count;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/range_mode_frequency_query.sv @@
// Top level of the range mode frequency query block: element store, count store and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// The block holds an array of up to MAX_LEN 12-bit values (at most 4096 positions are
// addressable) and answers range queries over it. A load transaction (s_tuser = 0) writes one
// element; a load whose index is at or beyond MAX_LEN is dropped. A query transaction
// (s_tuser = 1) names an inclusive range [left, right], with right saturated to MAX_LEN-1.
// The block reports the largest number of times any one value occurs in the range and
// max(2*count - length, 1). An empty range (left above the saturated right) returns with
// bad_range set, a count of zero and an answer of one. For any other query the count walk
// streams one element per cycle through the element memory and a read-modify-write of the
// 4096-entry count memory, then a second walk zeroes the touched counts, one element per
// cycle, and the result is then handed to the output register. The rate is set by the single
// element read port, which both walks share. A finished result waits in its own output
// register, so loads and a new query are taken whenever the block is idle, also while a
// result still waits on the master side; a later result then waits in turn until the master
// side takes the earlier one. After reset the block zeroes the count memory, one entry per
// cycle, with s_tready low.
module range_mode_frequency_query #(
    parameter int unsigned MAX_LEN = 4096
) (
    input  wire                                logic aclk,
    input  wire                                logic aresetn,
    // Input transactions.
    input  wire                                logic s_tvalid,
    output logic                               s_tready,
    // s_tdata, lowest bit up: index[11:0], value[23:12], left[35:24], right[47:36].
    input  wire logic [rmfq_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type (0 load, 1 query).
    input  wire                                logic s_tuser,
    // Result transactions.
    output logic                               m_tvalid,
    input  wire                                logic m_tready,
    // m_tdata, lowest bit up: mode_count[12:0], answer[25:13], zero fill[31:26].
    output logic [rmfq_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: bad_range.
    output logic                               m_tuser
);
    import rmfq_pkg::*;

    // Highest usable position, limited by the 12-bit position fields.
    localparam logic [POS_W-1:0] HI_CAP =
        (MAX_LEN > (1 << POS_W)) ? {POS_W{1'b1}} : POS_W'(MAX_LEN - 1);
    localparam int unsigned DEPTH = int'(HI_CAP) + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Unpacked input fields.
    logic [POS_W-1:0] in_index, in_left, in_right, in_hi;
    logic [VAL_W-1:0] in_value;

    assign in_index = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[POS_W+VAL_W-1:POS_W];
    assign in_left  = s_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W];
    assign in_right = s_tdata[3*POS_W+VAL_W-1:2*POS_W+VAL_W];
    assign in_hi    = (in_right > HI_CAP) ? HI_CAP : in_right;

    // Control and datapath registers.
    logic [2:0]       state_reg, state_next;
    logic [VAL_W-1:0] init_ptr_reg, init_ptr_next;
    logic [POS_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             issue_reg, issue_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic [VAL_W-1:0] s2_val_reg;
    logic             fw_valid_reg, fw_valid_next;
    logic [VAL_W-1:0] fw_addr_reg;
    logic [CNT_W-1:0] fw_data_reg;
    logic [CNT_W-1:0] best_reg, best_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    // Memories and their read data.
    logic [VAL_W-1:0] elem_mem [DEPTH];
    logic [CNT_W-1:0] cnt_mem  [VAL_DEPTH];
    logic [VAL_W-1:0] elem_rd_reg;
    logic [CNT_W-1:0] cnt_rd_reg;

    logic             elem_we;
    logic             cnt_we;
    logic [VAL_W-1:0] cnt_wa;
    logic [CNT_W-1:0] cnt_wd;

    logic             accept;
    logic [CNT_W-1:0] cnt_old, cnt_new;
    logic [CNT_W-1:0] span;
    logic signed [CNT_W+1:0] diff;
    logic             walk_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign elem_we  = accept && (s_tuser == REQ_LOAD) && (in_index <= HI_CAP);

    // Element memory: written by loads, read by both walks.
    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[AW'(in_index)] <= in_value;
        end
        elem_rd_reg <= elem_mem[ptr_reg];
    end

    // The count of the previous element may still be in flight when the next one reads
    // the same entry, so the value just written is forwarded.
    assign cnt_old = (fw_valid_reg && (fw_addr_reg == s2_val_reg)) ? fw_data_reg : cnt_rd_reg;
    assign cnt_new = cnt_old + CNT_W'(1);

    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = s2_val_reg;
        cnt_wd = cnt_new;
        if (state_reg == ST_INIT) begin
            cnt_we = 1'b1;
            cnt_wa = init_ptr_reg;
            cnt_wd = '0;
        end else if (state_reg == ST_COUNT && s2_valid_reg) begin
            cnt_we = 1'b1;
        end else if (state_reg == ST_CLEAR && s1_valid_reg) begin
            cnt_we = 1'b1;
            cnt_wa = elem_rd_reg;
            cnt_wd = '0;
        end
    end

    // Count memory: one entry per possible value.
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd_reg <= cnt_mem[elem_rd_reg];
    end

    // Result arithmetic: length and max(2*count - length, 1).
    assign span = CNT_W'(hi_reg - lo_reg) + CNT_W'(1);
    assign diff = $signed({1'b0, best_reg, 1'b0}) - $signed({2'b00, span});
    assign walk_last = (ptr_reg == AW'(hi_reg));

    always_comb begin
        state_next    = state_reg;
        init_ptr_next = init_ptr_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ptr_next      = ptr_reg;
        issue_next    = issue_reg;
        s1_valid_next = 1'b0;
        s2_valid_next = 1'b0;
        fw_valid_next = 1'b0;
        best_next     = best_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_INIT: begin
                init_ptr_next = init_ptr_reg + VAL_W'(1);
                if (init_ptr_reg == {VAL_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && s_tuser == REQ_QUERY) begin
                    lo_next   = in_left;
                    hi_next   = in_hi;
                    best_next = '0;
                    if (in_left > in_hi) begin
                        res_next.bad_range  = 1'b1;
                        res_next.mode_count = '0;
                        res_next.answer     = CNT_W'(1);
                        state_next          = ST_DONE;
                    end else begin
                        ptr_next   = AW'(in_left);
                        issue_next = 1'b1;
                        state_next = ST_COUNT;
                    end
                end
            end
            ST_COUNT: begin
                s1_valid_next = issue_reg;
                s2_valid_next = s1_valid_reg;
                if (issue_reg) begin
                    if (walk_last) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                if (s2_valid_reg) begin
                    fw_valid_next = 1'b1;
                    if (cnt_new > best_reg) begin
                        best_next = cnt_new;
                    end
                end
                if (!issue_reg && !s1_valid_reg && !s2_valid_reg) begin
                    ptr_next   = AW'(lo_reg);
                    issue_next = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                s1_valid_next = issue_reg;
                if (issue_reg) begin
                    if (walk_last) begin
                        issue_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                if (!issue_reg && !s1_valid_reg) begin
                    res_next.bad_range  = 1'b0;
                    res_next.mode_count = best_reg;
                    res_next.answer     = (diff < 1) ? CNT_W'(1) : CNT_W'(diff);
                    state_next          = ST_DONE;
                end
            end
            ST_DONE: begin
                // The result moves to the output register once the previous one is gone.
                if (!m_valid_reg || m_tready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_ptr_reg <= '0;
            issue_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_ptr_reg <= init_ptr_next;
            issue_reg    <= issue_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            fw_valid_reg <= fw_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        ptr_reg     <= ptr_next;
        s2_val_reg  <= elem_rd_reg;
        fw_addr_reg <= s2_val_reg;
        fw_data_reg <= cnt_new;
        best_reg    <= best_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.bad_range;
    assign m_tdata  = {(M_TDATA_W - 2*CNT_W)'(0), out_reg.answer, out_reg.mode_count};

endmodule
`default_nettype wire

@@ rtl/core/rmfq_checker.sv @@
// Port-level checker for the range mode frequency query block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module rmfq_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [rmfq_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire logic                               m_tuser
);
    import rmfq_pkg::*;

    logic [CNT_W-1:0] mode_count;
    logic [CNT_W-1:0] answer;

    assign mode_count = m_tdata[CNT_W-1:0];
    assign answer     = m_tdata[2*CNT_W-1:CNT_W];

    // A reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An empty range reports a zero count and an answer of one.
    a_bad_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> mode_count == '0 && answer == CNT_W'(1))
        else $error("empty range result malformed");

    // A non-empty range contains at least one element; the answer is from one to the count.
    a_good_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> mode_count != '0 && answer != '0 &&
                                 answer <= mode_count)
        else $error("counted result out of range");

    // No input is taken while the block is busy with a query that has no result yet.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_QUERY |=> !s_tready)
        else $error("input accepted during a query");

endmodule

bind range_mode_frequency_query rmfq_checker u_rmfq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

@@ tb/range_mode_frequency_query_tb.sv @@
// Self-checking testbench for the range mode frequency query block.
`timescale 1ns / 1ps
module range_mode_frequency_query_tb;
    import rmfq_pkg::*;

    localparam int unsigned MAX_LEN = 4096;
    localparam int unsigned WIN = 16;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned RANDOM_ITEMS = 50;
    localparam int unsigned QUIET_AFTER = 40;

    // One input transaction as it travels on s_tdata, index in the lowest bits.
    typedef struct packed {
        logic [POS_W-1:0] right;
        logic [POS_W-1:0] left;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] index;
    } req_fields_t;

    typedef struct {
        logic        kind;
        req_fields_t fields;
        bit          has_golden;
        result_t     golden;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Mirror of the block state: element array and per-value tallies.
    logic [VAL_W-1:0] element_mirror [MAX_LEN];
    logic [CNT_W-1:0] value_tally [VAL_DEPTH];

    // Predictions enter at the front and leave at the back.
    result_t     pending_results [$];
    stim_row_t   directed_rows [$];
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned loads_sent = 0;
    int unsigned queries_sent = 0;
    int unsigned empty_queries = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    bit          quiet = 1'b0;

    range_mode_frequency_query #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("range_mode_frequency_query_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s is %0d, expected %0d", cycle_count, what, got, want);
        mismatches++;
    endtask

    // Largest occurrence count in [lo, hi] and max(2*count - length, 1).
    function automatic result_t range_mode(input logic [POS_W-1:0] lo,
                                           input logic [POS_W-1:0] hi_in);
        int      hi;
        int      best;
        int      span;
        int      score;
        result_t r;
        hi = int'(hi_in);
        if (hi > MAX_LEN - 1)
            hi = MAX_LEN - 1;
        r = '0;
        if (int'(lo) > hi) begin
            r.bad_range = 1'b1;
            r.answer = CNT_W'(1);
            return r;
        end
        best = 0;
        for (int i = int'(lo); i <= hi; i++) begin
            value_tally[element_mirror[i]] = value_tally[element_mirror[i]] + CNT_W'(1);
            if (int'(value_tally[element_mirror[i]]) > best)
                best = int'(value_tally[element_mirror[i]]);
        end
        for (int i = int'(lo); i <= hi; i++)
            value_tally[element_mirror[i]] = '0;
        span = hi - int'(lo) + 1;
        score = 2 * best - span;
        if (score < 1)
            score = 1;
        r.mode_count = best[CNT_W-1:0];
        r.answer = score[CNT_W-1:0];
        return r;
    endfunction

    // Drives one transaction at the falling edge, possibly after a random gap, and
    // updates the mirror once the block has taken it.
    task automatic send_item(input logic kind, input req_fields_t f,
                             input bit has_golden, input result_t golden);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= f;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (kind == REQ_LOAD) begin
            loads_sent++;
            if (f.index < MAX_LEN)
                element_mirror[f.index] = f.value;
        end else begin
            queries_sent++;
            if (f.left > f.right)
                empty_queries++;
            if (has_golden)
                pending_results.push_front(golden);
            else
                pending_results.push_front(range_mode(f.left, f.right));
        end
    endtask

    task automatic send_load(input int unsigned idx, input int unsigned val);
        req_fields_t f;
        f.index = POS_W'(idx);
        f.value = VAL_W'(val);
        f.left = POS_W'($urandom_range(0, 4095));
        f.right = POS_W'($urandom_range(0, 4095));
        send_item(REQ_LOAD, f, 1'b0, '0);
    endtask

    task automatic send_query(input int unsigned lo, input int unsigned hi);
        req_fields_t f;
        f.index = POS_W'($urandom_range(0, 4095));
        f.value = VAL_W'($urandom_range(0, 4095));
        f.left = POS_W'(lo);
        f.right = POS_W'(hi);
        send_item(REQ_QUERY, f, 1'b0, '0);
    endtask

    task automatic add_row(input logic kind, input int unsigned idx, input int unsigned val,
                           input int unsigned lo, input int unsigned hi,
                           input bit has_golden, input int unsigned cnt,
                           input int unsigned ans, input bit bad);
        stim_row_t row;
        row.kind = kind;
        row.fields.index = POS_W'(idx);
        row.fields.value = VAL_W'(val);
        row.fields.left = POS_W'(lo);
        row.fields.right = POS_W'(hi);
        row.has_golden = has_golden;
        row.golden.mode_count = CNT_W'(cnt);
        row.golden.answer = CNT_W'(ans);
        row.golden.bad_range = bad;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Result side: random stall bursts until the final quiet stretch.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Each result transaction is checked against the oldest pending prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, mode_count", int'(m_tdata[12:0]), -1);
            end else begin
                want = pending_results.pop_back();
                if (m_tdata[12:0] !== want.mode_count)
                    report_mismatch("mode_count", int'(m_tdata[12:0]),
                                    int'(want.mode_count));
                if (m_tdata[25:13] !== want.answer)
                    report_mismatch("answer", int'(m_tdata[25:13]), int'(want.answer));
                if (m_tuser !== want.bad_range)
                    report_mismatch("bad_range", int'(m_tuser), int'(want.bad_range));
                if (m_tdata[31:26] !== '0)
                    report_mismatch("zero fill of m_tdata", int'(m_tdata[31:26]), 0);
            end
        end
    end

    initial begin
        int unsigned first_random;
        int unsigned win_base;
        int unsigned len;
        int unsigned base;
        int unsigned lo;
        int unsigned hi;
        int unsigned v0;
        int unsigned v1;
        int unsigned n_loads;
        int unsigned pick;

        for (int i = 0; i < MAX_LEN; i++) begin
            element_mirror[i] = '0;
        end
        for (int i = 0; i < VAL_DEPTH; i++) begin
            value_tally[i] = '0;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A window at each end of the array is written with the top value. Every query
        // below stays inside these windows, so none touches an element never loaded.
        for (int i = 0; i < WIN; i++) begin
            send_load(i, 4095);
            send_load(MAX_LEN - WIN + i, 4095);
        end

        // Directed rows; a golden result is typed in where it is obvious.
        //      kind       index  value  left   right  gold cnt   ans   bad
        add_row(REQ_QUERY, 0,     0,     0,     15,    1,   16,   16,   0);
        add_row(REQ_QUERY, 0,     0,     4095,  4095,  1,   1,    1,    0);
        add_row(REQ_QUERY, 0,     0,     0,     0,     1,   1,    1,    0);
        add_row(REQ_QUERY, 0,     0,     4095,  0,     1,   0,    1,    1);
        add_row(REQ_QUERY, 0,     0,     1,     0,     1,   0,    1,    1);
        add_row(REQ_LOAD,  0,     0,     0,     0,     0,   0,    0,    0);
        add_row(REQ_LOAD,  4095,  0,     0,     0,     0,   0,    0,    0);
        add_row(REQ_LOAD,  1,     'hAAA, 0,     0,     0,   0,    0,    0);
        add_row(REQ_LOAD,  2,     'h555, 0,     0,     0,   0,    0,    0);
        add_row(REQ_QUERY, 0,     0,     0,     3,     1,   1,    1,    0);
        add_row(REQ_LOAD,  3,     0,     0,     0,     0,   0,    0,    0);
        add_row(REQ_QUERY, 0,     0,     0,     3,     1,   2,    1,    0);
        add_row(REQ_QUERY, 0,     0,     4094,  4095,  1,   1,    1,    0);
        add_row(REQ_QUERY, 0,     0,     4080,  4095,  0,   0,    0,    0);
        add_row(REQ_QUERY, 'hFFF, 'hFFF, 8,     11,    1,   4,    4,    0);
        add_row(REQ_LOAD,  5,     7,     'hFFF, 'hFFF, 0,   0,    0,    0);
        add_row(REQ_QUERY, 0,     0,     4,     6,     1,   2,    1,    0);
        add_row(REQ_QUERY, 0,     0,     3,     0,     1,   0,    1,    1);
        add_row(REQ_QUERY, 'h555, 'hAAA, 0,     15,    0,   0,    0,    0);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].kind, directed_rows[i].fields,
                      directed_rows[i].has_golden, directed_rows[i].golden);
        end

        // Random part. Most of it loads a few elements into a stretch of one window from
        // a small pool of values, so that modes form, and then queries that stretch.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            if (items_sent - first_random >= QUIET_AFTER)
                quiet = 1'b1;
            pick = $urandom_range(0, 9);
            win_base = ($urandom_range(0, 1) == 0) ? 0 : MAX_LEN - WIN;
            if (pick < 7) begin
                len = $urandom_range(1, WIN);
                base = win_base + $urandom_range(0, WIN - len);
                v0 = $urandom_range(0, 4095);
                v1 = $urandom_range(0, 4095);
                n_loads = $urandom_range(0, 4);
                repeat (n_loads) begin
                    send_load(base + $urandom_range(0, len - 1),
                              ($urandom_range(0, 2) == 0) ? v1 : v0);
                end
                lo = base;
                hi = base + len - 1;
                // Sometimes only part of the stretch is asked.
                if ($urandom_range(0, 3) == 0) begin
                    lo = $urandom_range(base, hi);
                    hi = $urandom_range(lo, hi);
                end
                send_query(lo, hi);
            end else if (pick == 7) begin
                send_load($urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (pick == 8) begin
                lo = $urandom_range(1, 4095);
                send_query(lo, $urandom_range(0, lo - 1));
            end else begin
                lo = win_base + $urandom_range(0, WIN - 1);
                hi = lo + $urandom_range(0, WIN - 1);
                send_query(lo, (hi > win_base + WIN - 1) ? win_base + WIN - 1 : hi);
            end
        end
        quiet = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        // A short drain so that any stray extra result is still caught.
        repeat (50) @(posedge aclk);

        $display("sent %0d loads and %0d queries (%0d with an empty range)",
                 loads_sent, queries_sent, empty_queries);
        $display("checked %0d results, %0d mismatches, %0d cycles",
                 results_seen, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("range_mode_frequency_query_tb OK");
        end else begin
            $display("range_mode_frequency_query_tb NOT OK");
        end
        $finish;
    end

endmodule
